/* rtl/core/rgbaunp_pkg.sv */
package rgbaunp_pkg;

    localparam int PIX_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 3;   // red, green, blue; alpha rides along
    localparam int NUM_W   = 16;  // c*255 + alpha/2 stays below 2^16
    localparam int RECIP_W = 17;  // floor(2^16 / alpha), alpha >= 1
    localparam int QUO_W   = 17;
    localparam int PROD_W  = QUO_W + CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;
    localparam logic [CHAN_W-1:0] ALPHA_ZERO = 8'd0;

    // Sideband that travels with each pixel down the pipe.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
        logic             bypass;   // alpha is 0 or 255: colors pass unchanged
    } side_t;

    typedef logic [NCHAN-1:0][NUM_W-1:0]   num_arr_t;
    typedef logic [NCHAN-1:0][QUO_W-1:0]   quo_arr_t;
    typedef logic [NCHAN-1:0][PROD_W-1:0]  prod_arr_t;

endpackage

/* rtl/core/rgba_unpremultiply_alpha.sv */
// Alpha unpremultiply for RGBA8 pixels.
//
// Input stream s_*: s_tdata carries a premultiplied pixel (red in bits 7:0,
// green 15:8, blue 23:16, alpha 31:24), s_tlast marks the last pixel of a
// frame. Output stream m_*: m_tdata is the straight-alpha pixel in the same
// layout, m_tlast a copy of the input flag. Alpha passes through untouched;
// colors with alpha 0 or 255 pass unchanged, otherwise each becomes
// min(255, (c*255 + alpha/2) / alpha).
//
// The pipe has four register stages: a pixel is registered through stages 1,
// 2, 3 and 4 in order, and m_tvalid is the stage 4 valid. One pixel per clock
// is sustained while m_tready stays high: the division is a reciprocal-table
// lookup, a 16x17 multiply, a back multiply and a one-step correction, each in
// its own register stage.
//
// Reset (aresetn low, synchronous) empties the pipe. When the receiver holds
// m_tready low the output stage holds its transaction, earlier stages keep
// filling any empty slot, and s_tready drops only once every stage is full.
module rgba_unpremultiply_alpha (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rgbaunp_pkg::PIX_W-1:0]   s_tdata,   // pixel_in
    input  logic                            s_tlast,   // last_in
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [rgbaunp_pkg::PIX_W-1:0]   m_tdata,   // pixel_out
    output logic                            m_tlast    // last_out
);
    import rgbaunp_pkg::*;

    // Reciprocal table, floor(2^16 / alpha); zero where alpha bypasses.
    logic [255:0][RECIP_W-1:0] recip_lut;
    for (genvar g = 0; g < 256; g++) begin : g_recip
        localparam int Div      = (g == 0) ? 1 : g;
        localparam int RecipVal = (g == 0 || g == 255) ? 0 : 65536 / Div;
        assign recip_lut[g] = RECIP_W'(RecipVal);
    end

    // Handshake / valid chain
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || m_tready;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: numerators and reciprocal lookup
    logic [CHAN_W-1:0]  alpha_in;
    num_arr_t           num_next;
    side_t              side1_next;
    side_t              side1_reg, side2_reg, side3_reg;
    num_arr_t           num1_reg, num2_reg, num3_reg;
    logic [RECIP_W-1:0] recip1_reg;

    assign alpha_in = s_tdata[PIX_W-1 -: CHAN_W];

    always_comb begin
        logic [CHAN_W-1:0] c;
        for (int i = 0; i < NCHAN; i++) begin
            c = s_tdata[i*CHAN_W +: CHAN_W];
            // c*255 = (c << 8) - c
            num_next[i] = ({c, 8'd0} - {8'd0, c}) + {9'd0, alpha_in[CHAN_W-1:1]};
        end
        side1_next.pixel  = s_tdata;
        side1_next.last   = s_tlast;
        side1_next.bypass = (alpha_in == ALPHA_ZERO) || (alpha_in == CHAN_MAX);
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            side1_reg  <= side1_next;
            num1_reg   <= num_next;
            recip1_reg <= recip_lut[alpha_in];
        end
    end

    // Stage 2: quotient estimate, floor(n * recip / 2^16), low by at most one
    quo_arr_t quo_est;
    quo_arr_t quo2_reg, quo3_reg;

    always_comb begin
        logic [NUM_W+RECIP_W-1:0] p;
        for (int i = 0; i < NCHAN; i++) begin
            p          = {{RECIP_W{1'b0}}, num1_reg[i]} * {{NUM_W{1'b0}}, recip1_reg};
            quo_est[i] = p[NUM_W+RECIP_W-1 -: QUO_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy2 && v1_reg) begin
            side2_reg <= side1_reg;
            num2_reg  <= num1_reg;
            quo2_reg  <= quo_est;
        end
    end

    // Stage 3: back multiply quotient by alpha
    logic [CHAN_W-1:0] alpha2;
    prod_arr_t         prod_next, prod3_reg;

    assign alpha2 = side2_reg.pixel[PIX_W-1 -: CHAN_W];

    always_comb begin
        for (int i = 0; i < NCHAN; i++) begin
            prod_next[i] = {{CHAN_W{1'b0}}, quo2_reg[i]} * {{QUO_W{1'b0}}, alpha2};
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            side3_reg <= side2_reg;
            num3_reg  <= num2_reg;
            quo3_reg  <= quo2_reg;
            prod3_reg <= prod_next;
        end
    end

    // Stage 4: remainder correction, saturation, bypass select
    logic [CHAN_W-1:0]                alpha3;
    logic [NCHAN-1:0][PROD_W-1:0]     rem;
    logic [PIX_W-1:0]                 pix_next;
    logic [PIX_W-1:0]                 pix4_reg;
    logic                             last4_reg;

    assign alpha3 = side3_reg.pixel[PIX_W-1 -: CHAN_W];

    always_comb begin
        logic [QUO_W-1:0] q;
        pix_next = side3_reg.pixel;
        for (int i = 0; i < NCHAN; i++) begin
            rem[i] = {{(PROD_W-NUM_W){1'b0}}, num3_reg[i]} - prod3_reg[i];
            q      = quo3_reg[i];
            if (rem[i] >= {{(PROD_W-CHAN_W){1'b0}}, alpha3}) begin
                q = q + QUO_W'(1);
            end
            if (!side3_reg.bypass) begin
                pix_next[i*CHAN_W +: CHAN_W] =
                    (q > {{(QUO_W-CHAN_W){1'b0}}, CHAN_MAX}) ? CHAN_MAX : q[CHAN_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            pix4_reg  <= pix_next;
            last4_reg <= side3_reg.last;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = pix4_reg;
    assign m_tlast  = last4_reg;

    // The reciprocal estimate is never more than one short.
    a_rem_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && !side3_reg.bypass |->
            rem[0] < {{(PROD_W-CHAN_W-1){1'b0}}, alpha3, 1'b0} &&
            rem[1] < {{(PROD_W-CHAN_W-1){1'b0}}, alpha3, 1'b0} &&
            rem[2] < {{(PROD_W-CHAN_W-1){1'b0}}, alpha3, 1'b0})
        else $error("unpremultiply remainder out of correction range");

    // Input backs up only when every stage holds a pixel and output stalls.
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> v1_reg && v2_reg && v3_reg && v4_reg && !m_tready)
        else $error("input stalled while pipeline has room");

    // Alpha leaves stage 4 as it entered the pipe.
    a_alpha_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        rdy4 && v3_reg |=> m_tdata[PIX_W-1 -: CHAN_W] == $past(alpha3))
        else $error("alpha byte altered");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !v1_reg)
        else $error("pipeline not empty after reset");

endmodule
